### src/sobol_sample_generator_top_defines.svh
// assertion macros for the sobol sample generator
// used by sobol_sample_generator_top, needs clk and rst_n in scope
`ifndef SOBOL_SAMPLE_GENERATOR_TOP_DEFINES_SVH
`define SOBOL_SAMPLE_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SOBOL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SOBOL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sobol_pkg.sv
// shared constants for the sobol sample generator
// no dependencies
`timescale 1ns / 1ps

package sobol_pkg;

    localparam int DIR_BITS   = 32;
    localparam int POS_W      = 5;
    localparam int DIM_PORT_W = 6;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_ODD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_EVEN = 2'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_GEN  = 1'b1;

endpackage

### src/sobol_sample_generator_top.sv
// sobol sample generator with cranley-patterson rotation, top level
// depends on sobol_pkg, sobol_ram and sobol_sample_generator_top_defines.svh
`timescale 1ns / 1ps

// A load request (cmd 0) writes one direction word in the cycle it is taken and
// leaves busy low, so loads go at one per cycle outside a walk. A generate
// request (cmd 1) walks the 32 words of its dimension through the single table
// port, one position a cycle, reading only words whose index bits are set; done
// pulses for one cycle with raw_value and sample_frac, and busy drops in that
// same cycle. The result cannot be held off, so capture it when done is high.
// The shift registers may be written at any time through the cfg channel, which
// is always ready; the selected shift is sampled at the end of the walk.
`include "sobol_sample_generator_top_defines.svh"

module sobol_sample_generator_top #(
    parameter int MAX_DIMENSIONS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            cmd,
    input  logic [sobol_pkg::DIM_PORT_W-1:0] dim,
    input  logic [sobol_pkg::POS_W-1:0]     bit_pos,
    input  logic [sobol_pkg::WORD_W-1:0]    dir_word,
    input  logic [sobol_pkg::WORD_W-1:0]    sample_index,
    output logic                            done,
    output logic [sobol_pkg::WORD_W-1:0]    raw_value,
    output logic [sobol_pkg::WORD_W-1:0]    sample_frac,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sobol_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sobol_pkg::WORD_W-1:0]    cfg_data
);

    localparam int TABLE_DEPTH = MAX_DIMENSIONS * sobol_pkg::DIR_BITS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int DIM_AW      = ADDR_W - sobol_pkg::POS_W;
    // one spare bit so the dimension count itself fits the compare
    localparam int DIM_W       = ((DIM_AW > sobol_pkg::DIM_PORT_W) ? DIM_AW
                                                                   : sobol_pkg::DIM_PORT_W) + 1;
    localparam int POS_W       = sobol_pkg::POS_W;
    localparam int WORD_W      = sobol_pkg::WORD_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [POS_W-1:0]  rd_pos_reg, rd_pos_next;
    logic              sel_reg, sel_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] idx_reg, idx_next;
    logic [DIM_AW-1:0] dim_addr_reg, dim_addr_next;
    logic              dim_ok_reg, dim_ok_next;
    logic              odd_reg, odd_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] raw_reg, raw_next;
    logic [WORD_W-1:0] frac_reg, frac_next;
    logic [WORD_W-1:0] shift_odd_reg, shift_even_reg;

    logic [DIM_W-1:0]  dim_ext;
    logic              in_ok;
    logic              accept;
    logic              ram_en, ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] masked_data;
    logic [WORD_W-1:0] raw_final;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign raw_value = raw_reg;
    assign sample_frac = frac_reg;

    assign dim_ext = DIM_W'(dim);
    assign in_ok   = (dim_ext < DIM_W'(MAX_DIMENSIONS));

    // table port: load writes while idle, the walk reads only words the index selects
    always_comb
    begin
        if (busy)
        begin
            ram_en   = (state_reg == ST_RUN) && dim_ok_reg && idx_reg[rd_pos_reg];
            ram_we   = 1'b0;
            ram_addr = {dim_addr_reg, rd_pos_reg};
        end
        else
        begin
            ram_en   = accept && (cmd == sobol_pkg::CMD_LOAD) && in_ok;
            ram_we   = ram_en;
            ram_addr = {dim_ext[DIM_AW-1:0], bit_pos};
        end
    end

    sobol_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (dir_word),
        .rdata (ram_rdata)
    );

    // word read last cycle counts only when its index bit was set
    assign masked_data = sel_reg ? ram_rdata : '0;
    assign raw_final   = acc_reg ^ masked_data;

    always_comb
    begin
        state_next    = state_reg;
        rd_pos_next   = rd_pos_reg;
        sel_next      = sel_reg;
        acc_next      = acc_reg;
        idx_next      = idx_reg;
        dim_addr_next = dim_addr_reg;
        dim_ok_next   = dim_ok_reg;
        odd_next      = odd_reg;
        done_next     = 1'b0;
        raw_next      = raw_reg;
        frac_next     = frac_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == sobol_pkg::CMD_GEN))
                begin
                    state_next    = ST_RUN;
                    rd_pos_next   = '0;
                    sel_next      = 1'b0;
                    acc_next      = '0;
                    idx_next      = sample_index;
                    dim_addr_next = dim_ext[DIM_AW-1:0];
                    dim_ok_next   = in_ok;
                    odd_next      = dim[0];
                end
            end
            ST_RUN:
            begin
                acc_next    = raw_final;
                sel_next    = dim_ok_reg && idx_reg[rd_pos_reg];
                rd_pos_next = rd_pos_reg + 1'b1;
                if (rd_pos_reg == POS_W'(sobol_pkg::DIR_BITS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                raw_next   = raw_final;
                frac_next  = raw_final + (odd_reg ? shift_odd_reg : shift_even_reg);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            rd_pos_reg     <= '0;
            sel_reg        <= 1'b0;
            shift_odd_reg  <= '0;
            shift_even_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            rd_pos_reg <= rd_pos_next;
            sel_reg    <= sel_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    sobol_pkg::CFG_SHIFT_ODD:  shift_odd_reg  <= cfg_data;
                    sobol_pkg::CFG_SHIFT_EVEN: shift_even_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        idx_reg      <= idx_next;
        dim_addr_reg <= dim_addr_next;
        dim_ok_reg   <= dim_ok_next;
        odd_reg      <= odd_next;
        raw_reg      <= raw_next;
        frac_reg     <= frac_next;
    end

    `SOBOL_ASSERT_NEXT(a_done_after_finish, state_reg == ST_FINISH, done_reg,
        "result missing after walk")
    `SOBOL_ASSERT_SAME(a_done_only_from_finish, done_reg, $past(state_reg) == ST_FINISH,
        "stray result strobe")
    `SOBOL_ASSERT_SAME(a_write_idle_only, ram_we, !busy, "table write during walk")
    `SOBOL_ASSERT_NEXT(a_gen_goes_busy, accept && (cmd == sobol_pkg::CMD_GEN),
        busy && !done_reg, "generate request not started")
    `SOBOL_ASSERT_NEXT(a_walk_steps, (state_reg == ST_RUN) && (rd_pos_reg != '1),
        (state_reg == ST_RUN) && (rd_pos_reg == $past(rd_pos_reg) + 1'b1),
        "walk position skipped")

endmodule

### src/sobol_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sobol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
